@@ sv/sfq_pkg.sv @@
package sfq_pkg;

    // Default geometry
    localparam int DEPTH_DEF      = 16;
    localparam int VALUE_BITS_DEF = 31;

    // Fixed field widths
    localparam int FUNC_W  = 2;
    localparam int VALUE_W = 31;
    localparam int STAT_W  = 2;
    localparam int OCC_W   = 5;

    // Operation codes
    localparam logic [FUNC_W-1:0] FUNC_PUSH   = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_POP    = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd2;
    localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd3;

    // Status codes
    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

    // Microprogram addresses
    typedef logic [3:0] step_t;

    localparam step_t S_IDLE      = 4'd0;
    localparam step_t S_DISP      = 4'd1;
    localparam step_t S_PUSH_CHK  = 4'd2;
    localparam step_t S_PUSH_WR   = 4'd3;
    localparam step_t S_PUSH_FULL = 4'd4;
    localparam step_t S_POP_CHK   = 4'd5;
    localparam step_t S_POP_LD    = 4'd6;
    localparam step_t S_POP_EMPTY = 4'd7;
    localparam step_t S_SCAN_RD   = 4'd8;
    localparam step_t S_SCAN_CMP  = 4'd9;
    localparam step_t S_SCAN_NEXT = 4'd10;
    localparam step_t S_FOUND     = 4'd11;
    localparam step_t S_SH_RD     = 4'd12;
    localparam step_t S_SH_WR     = 4'd13;
    localparam step_t S_SH_FIN    = 4'd14;
    localparam step_t S_DONE      = 4'd15;

    // Branch conditions: jump when true, else take the next field (C_DISPATCH goes to the entry point of the operation)
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_NO_INPUT,
        C_DISPATCH,
        C_FULL,
        C_EMPTY,
        C_PTR_END,
        C_MATCH,
        C_IS_FIND,
        C_SH_END,
        C_OUT_BUSY
    } cond_t;

    // One control word
    typedef struct packed {
        cond_t cond;
        step_t jump;
        step_t next;
        logic  ld_in;      // input transfer allowed, load operands
        logic  rd_ptr;     // read entry at ptr
        logic  rd_ptr1;    // read entry at ptr + 1
        logic  wr_tail;    // write operand at count
        logic  wr_shift;   // write read data at ptr
        logic  cnt_inc;
        logic  cnt_dec;
        logic  ptr_inc;
        logic  set_full;
        logic  set_empty;
        logic  set_found;
        logic  ld_result;
        logic  emit;       // load the output register
    } ctrl_t;

    // Datapath status seen by the sequencer
    typedef struct packed {
        logic              in_valid;
        logic              full;
        logic              empty;
        logic              ptr_end;
        logic              sh_end;
        logic              match;
        logic              is_find;
        logic              out_busy;
        logic [FUNC_W-1:0] func;
    } flags_t;

    // Control store
    function automatic ctrl_t ucode(step_t s);
        ctrl_t w;
        w      = '0;
        w.cond = C_ALWAYS;
        unique case (s)
            S_IDLE:
            begin
                w.ld_in = 1'b1;
                w.cond  = C_NO_INPUT;
                w.jump  = S_IDLE;
                w.next  = S_DISP;
            end
            S_DISP:
            begin
                w.cond = C_DISPATCH;
            end
            S_PUSH_CHK:
            begin
                w.cond = C_FULL;
                w.jump = S_PUSH_FULL;
                w.next = S_PUSH_WR;
            end
            S_PUSH_WR:
            begin
                w.wr_tail = 1'b1;
                w.cnt_inc = 1'b1;
                w.jump    = S_DONE;
            end
            S_PUSH_FULL:
            begin
                w.set_full = 1'b1;
                w.jump     = S_DONE;
            end
            S_POP_CHK:
            begin
                w.rd_ptr = 1'b1;
                w.cond   = C_EMPTY;
                w.jump   = S_POP_EMPTY;
                w.next   = S_POP_LD;
            end
            S_POP_LD:
            begin
                w.ld_result = 1'b1;
                w.jump      = S_SH_RD;
            end
            S_POP_EMPTY:
            begin
                w.set_empty = 1'b1;
                w.jump      = S_DONE;
            end
            S_SCAN_RD:
            begin
                w.rd_ptr = 1'b1;
                w.cond   = C_PTR_END;
                w.jump   = S_DONE;
                w.next   = S_SCAN_CMP;
            end
            S_SCAN_CMP:
            begin
                w.cond = C_MATCH;
                w.jump = S_FOUND;
                w.next = S_SCAN_NEXT;
            end
            S_SCAN_NEXT:
            begin
                w.ptr_inc = 1'b1;
                w.jump    = S_SCAN_RD;
            end
            S_FOUND:
            begin
                w.set_found = 1'b1;
                w.cond      = C_IS_FIND;
                w.jump      = S_DONE;
                w.next      = S_SH_RD;
            end
            S_SH_RD:
            begin
                w.rd_ptr1 = 1'b1;
                w.cond    = C_SH_END;
                w.jump    = S_SH_FIN;
                w.next    = S_SH_WR;
            end
            S_SH_WR:
            begin
                w.wr_shift = 1'b1;
                w.ptr_inc  = 1'b1;
                w.jump     = S_SH_RD;
            end
            S_SH_FIN:
            begin
                w.cnt_dec = 1'b1;
                w.jump    = S_DONE;
            end
            S_DONE:
            begin
                w.emit = 1'b1;
                w.cond = C_OUT_BUSY;
                w.jump = S_DONE;
                w.next = S_IDLE;
            end
            default:
            begin
                w.jump = S_IDLE;
            end
        endcase
        return w;
    endfunction

    // Entry point per operation
    function automatic step_t dispatch(logic [FUNC_W-1:0] f);
        step_t s;
        unique case (f)
            FUNC_PUSH:   s = S_PUSH_CHK;
            FUNC_POP:    s = S_POP_CHK;
            FUNC_FIND:   s = S_SCAN_RD;
            FUNC_REMOVE: s = S_SCAN_RD;
            default:     s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

@@ sv/sfq_seq.sv @@
module sfq_seq
    import sfq_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  flags_t flags,
    output ctrl_t  ctrl
);

    step_t upc_reg;
    step_t upc_next;
    logic  take;

    // Current control word
    assign ctrl = ucode(upc_reg);

    // Branch condition select
    always_comb
    begin
        unique case (ctrl.cond)
            C_ALWAYS:   take = 1'b1;
            C_NO_INPUT: take = !flags.in_valid;
            C_DISPATCH: take = 1'b0;
            C_FULL:     take = flags.full;
            C_EMPTY:    take = flags.empty;
            C_PTR_END:  take = flags.ptr_end;
            C_MATCH:    take = flags.match;
            C_IS_FIND:  take = flags.is_find;
            C_SH_END:   take = flags.sh_end;
            C_OUT_BUSY: take = flags.out_busy;
            default:    take = 1'b1;
        endcase
    end

    // Next address
    always_comb
    begin
        if (ctrl.cond == C_DISPATCH)
        begin
            upc_next = dispatch(flags.func);
        end
        else if (take)
        begin
            upc_next = ctrl.jump;
        end
        else
        begin
            upc_next = ctrl.next;
        end
    end

    // Step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            upc_reg <= S_IDLE;
        end
        else
        begin
            upc_reg <= upc_next;
        end
    end

endmodule

@@ sv/searchable_fifo_queue_unit.sv @@
// Searchable FIFO queue of descriptor numbers.
// Input channel (in_valid/in_ready, func, value): one transfer is one
// operation: push, pop, find, or remove the first entry equal to value.
// Output channel (out_valid/out_ready, result_value, found, status,
// occupancy): exactly one result transfer per operation, in order.
// Control is a 16-step microprogram; the entry store has one write and one
// registered read port, so the scan and the gap-closing shift work through
// the entries one at a time.
// The longest operation is a remove of the tail entry of a full queue.
// in_ready is high only between operations (one item at a time); it returns
// in the cycle after the result loads.
// The result sits in an output register; while the receiver stalls, the
// block finishes the next operation and holds in its last step until the
// output register frees.
// Reset empties the queue (count to zero) and drops any pending result;
// entry contents are not cleared; unwritten entries may be read but never used.
module searchable_fifo_queue_unit
    import sfq_pkg::*;
#(
    parameter int DEPTH      = DEPTH_DEF,
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [FUNC_W-1:0]  func,
    input  logic [VALUE_W-1:0] value,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [VALUE_W-1:0] result_value,
    output logic               found,
    output logic [STAT_W-1:0]  status,
    output logic [OCC_W-1:0]   occupancy
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ctrl_t  ctrl;
    flags_t flags;

    logic [FUNC_W-1:0]     func_reg;
    logic [VALUE_BITS-1:0] value_reg;
    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      ptr_reg;
    logic [VALUE_BITS-1:0] rdata_reg;
    logic [VALUE_BITS-1:0] res_reg;
    logic                  fnd_reg;
    logic [STAT_W-1:0]     st_reg;

    logic                  out_valid_reg;
    logic [VALUE_W-1:0]    result_value_reg;
    logic                  found_reg;
    logic [STAT_W-1:0]     status_reg;
    logic [OCC_W-1:0]      occupancy_reg;

    logic [VALUE_BITS-1:0] mem [DEPTH];

    logic                  in_xfer;
    logic                  out_load;
    logic [31:0]           value_ext;
    logic [31:0]           res_ext;
    logic [31:0]           cnt_ext;
    logic [CNT_W:0]        ptr1;
    logic [CNT_W-1:0]      rd_idx;
    logic                  mem_we;
    logic [AW-1:0]         wr_addr;
    logic [VALUE_BITS-1:0] wr_data;

    sfq_seq u_seq
    (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    // Handshake and width adaption
    assign in_ready  = ctrl.ld_in;
    assign in_xfer   = in_valid && ctrl.ld_in;
    assign out_load  = ctrl.emit && (!out_valid_reg || out_ready);
    assign value_ext = 32'(value);
    assign res_ext   = 32'(res_reg);
    assign cnt_ext   = 32'(count_reg);
    assign ptr1      = {1'b0, ptr_reg} + (CNT_W + 1)'(1);

    // Status to the sequencer
    always_comb
    begin
        flags.in_valid = in_valid;
        flags.full     = (count_reg == CNT_W'(DEPTH));
        flags.empty    = (count_reg == '0);
        flags.ptr_end  = (ptr_reg >= count_reg);
        flags.sh_end   = (ptr1 >= {1'b0, count_reg});
        flags.match    = (rdata_reg == value_reg);
        flags.is_find  = (func_reg == FUNC_FIND);
        flags.out_busy = out_valid_reg && !out_ready;
        flags.func     = func_reg;
    end

    // Store addressing
    assign rd_idx  = ctrl.rd_ptr1 ? ptr1[CNT_W-1:0] : ptr_reg;
    assign mem_we  = ctrl.wr_tail || ctrl.wr_shift;
    assign wr_addr = ctrl.wr_tail ? count_reg[AW-1:0] : ptr_reg[AW-1:0];
    assign wr_data = ctrl.wr_tail ? value_reg : rdata_reg;

    // Entry store: one write, one registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctrl.rd_ptr || ctrl.rd_ptr1)
        begin
            rdata_reg <= mem[rd_idx[AW-1:0]];
        end
    end

    // Operand and working registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            func_reg  <= func;
            value_reg <= value_ext[VALUE_BITS-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ptr_reg   <= '0;
            res_reg   <= '0;
            fnd_reg   <= 1'b0;
            st_reg    <= ST_OK;
        end
        else
        begin
            if (in_xfer)
            begin
                ptr_reg <= '0;
                res_reg <= '0;
                fnd_reg <= 1'b0;
                st_reg  <= ST_OK;
            end
            else if (ctrl.ptr_inc)
            begin
                ptr_reg <= ptr_reg + CNT_W'(1);
            end
            if (ctrl.cnt_inc)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (ctrl.cnt_dec)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
            if (ctrl.ld_result)
            begin
                res_reg <= rdata_reg;
            end
            if (ctrl.set_found)
            begin
                fnd_reg <= 1'b1;
            end
            if (ctrl.set_full)
            begin
                st_reg <= ST_FULL;
            end
            else if (ctrl.set_empty)
            begin
                st_reg <= ST_EMPTY;
            end
        end
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            result_value_reg <= '0;
            found_reg        <= 1'b0;
            status_reg       <= ST_OK;
            occupancy_reg    <= '0;
        end
        else if (out_load)
        begin
            out_valid_reg    <= 1'b1;
            result_value_reg <= res_ext[VALUE_W-1:0];
            found_reg        <= fnd_reg;
            status_reg       <= st_reg;
            occupancy_reg    <= cnt_ext[OCC_W-1:0];
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign result_value = result_value_reg;
    assign found        = found_reg;
    assign status       = status_reg;
    assign occupancy    = occupancy_reg;

    // Checks
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("count above depth");

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= count_reg)
        else $error("pointer past count");

    a_inc_room: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cnt_inc |-> !flags.full)
        else $error("push into full store");

    a_dec_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.cnt_dec |-> !flags.empty)
        else $error("removal from empty store");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && st_reg == ST_FULL) |=> (occupancy == OCC_W'(cnt_ext)))
        else $error("full status with changed count");

endmodule

@@ verif/searchable_fifo_queue_unit_tb.sv @@
module searchable_fifo_queue_unit_tb
    import sfq_pkg::*;
;

    localparam int QDEPTH      = DEPTH_DEF;
    localparam int RAND_ITEMS  = 1800;
    localparam int MAX_REPORTS = 10;
    // Longest quiet stretch of a correct run is a full scan plus shift plus
    // sender gap and receiver stall.
    localparam int WDOG_LIMIT  = 1000;
    localparam int TAIL_WAIT   = 3 * QDEPTH + 20;

    typedef struct packed {
        logic [VALUE_W-1:0] ret_val;
        logic               hit;
        logic [STAT_W-1:0]  stat;
        logic [OCC_W-1:0]   occ;
    } reply_t;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

    logic               clk      = 1'b0;
    logic               rst_n    = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [FUNC_W-1:0]  func     = FUNC_PUSH;
    logic [VALUE_W-1:0] value    = '0;
    logic               out_valid;
    logic               out_ready = 1'b1;
    logic [VALUE_W-1:0] result_value;
    logic               found;
    logic [STAT_W-1:0]  status;
    logic [OCC_W-1:0]   occupancy;

    // Shadow copy of the queue contents, head at index 0
    logic [VALUE_W-1:0] shadow_q[$];
    reply_t             pending_replies[$];

    int in_gap_max    = 3;
    int out_stall_max = 3;
    int mismatches    = 0;
    int replies_seen  = 0;
    int items_sent    = 0;
    int n_full        = 0;
    int n_empty       = 0;
    int n_hits        = 0;
    int n_removed     = 0;

    searchable_fifo_queue_unit u_top
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .func         (func),
        .value        (value),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .found        (found),
        .status       (status),
        .occupancy    (occupancy)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    // Apply one operation to the shadow queue and return the reply it yields
    function automatic reply_t apply_queue_op(logic [FUNC_W-1:0] op,
                                              logic [VALUE_W-1:0] operand);
        reply_t r;
        int     pos;
        r    = '0;
        r.stat = ST_OK;
        pos  = -1;
        case (op)
            FUNC_PUSH:
            begin
                if (shadow_q.size() >= QDEPTH)
                begin
                    r.stat = ST_FULL;
                    n_full++;
                end
                else
                begin
                    shadow_q.push_back(operand);
                end
            end
            FUNC_POP:
            begin
                if (shadow_q.size() == 0)
                begin
                    r.stat = ST_EMPTY;
                    n_empty++;
                end
                else
                begin
                    r.ret_val = shadow_q.pop_front();
                end
            end
            default:
            begin
                // find and remove: first match nearest the head
                for (int i = 0; i < shadow_q.size(); i++)
                begin
                    if (shadow_q[i] == operand)
                    begin
                        pos = i;
                        break;
                    end
                end
                if (pos >= 0)
                begin
                    r.hit = 1'b1;
                    n_hits++;
                    if (op == FUNC_REMOVE)
                    begin
                        shadow_q.delete(pos);
                        n_removed++;
                    end
                end
            end
        endcase
        r.occ = OCC_W'(shadow_q.size());
        return r;
    endfunction

    function automatic logic [FUNC_W-1:0] pick_op(traffic_mix_t mix);
        int roll;
        int push_pct;
        int pop_pct;
        int find_pct;
        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                push_pct = 55;
                pop_pct  = 15;
                find_pct = 15;
            end
            MIX_DRAIN:
            begin
                push_pct = 15;
                pop_pct  = 45;
                find_pct = 15;
            end
            default:
            begin
                push_pct = 25;
                pop_pct  = 25;
                find_pct = 25;
            end
        endcase
        if (roll < push_pct)
            return FUNC_PUSH;
        if (roll < push_pct + pop_pct)
            return FUNC_POP;
        if (roll < push_pct + pop_pct + find_pct)
            return FUNC_FIND;
        return FUNC_REMOVE;
    endfunction

    // Searches mostly target live entries; small values give duplicates
    function automatic logic [VALUE_W-1:0] pick_value(logic [FUNC_W-1:0] op);
        int roll;
        roll = $urandom_range(0, 99);
        if ((op == FUNC_FIND || op == FUNC_REMOVE) && shadow_q.size() > 0 && roll < 60)
            return shadow_q[$urandom_range(0, shadow_q.size() - 1)];
        if (roll < 75)
            return VALUE_W'($urandom_range(0, 15));
        if (roll < 80)
            return ($urandom_range(0, 1) == 1) ? '1 : '0;
        return VALUE_W'($urandom);
    endfunction

    // One input transfer; expectation is recorded at the accepting edge
    task automatic send_op(input logic [FUNC_W-1:0] op, input logic [VALUE_W-1:0] operand);
        int gap;
        gap = $urandom_range(0, in_gap_max);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        func     <= op;
        value    <= operand;
        do @(posedge clk); while (in_ready !== 1'b1);
        pending_replies.push_back(apply_queue_op(op, operand));
        items_sent++;
    endtask

    // Hold off the sender until every outstanding reply has arrived
    task automatic wait_for_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
    endtask

    task automatic test_empty_queue();
        send_op(FUNC_POP, VALUE_W'($urandom));
        send_op(FUNC_FIND, '0);
        send_op(FUNC_REMOVE, '1);
    endtask

    // Fill with extremes and a duplicate, then push once more into a full queue
    task automatic test_fill_to_full();
        logic [VALUE_W-1:0] v;
        for (int i = 0; i < QDEPTH; i++)
        begin
            case (i)
                0:       v = '0;
                1:       v = '1;
                2:       v = 31'h2AAA_AAAA;
                3:       v = 31'h5555_5555;
                4, 9:    v = 31'd77;
                default: v = VALUE_W'($urandom);
            endcase
            send_op(FUNC_PUSH, v);
        end
        send_op(FUNC_PUSH, 31'd12345);
    endtask

    task automatic test_search_and_remove();
        send_op(FUNC_FIND, '1);
        send_op(FUNC_FIND, 31'd1234567);
        // duplicate: only the copy nearest the head goes
        send_op(FUNC_REMOVE, 31'd77);
        send_op(FUNC_REMOVE, shadow_q[shadow_q.size() - 1]);
        send_op(FUNC_POP, VALUE_W'($urandom));
    endtask

    task automatic test_pause_for_results();
        in_gap_max = 0;
        repeat (4) send_op(FUNC_PUSH, pick_value(FUNC_PUSH));
        wait_for_results();
        in_gap_max = 3;
    endtask

    // Phases of biased traffic so the queue swings between empty and full
    task automatic test_random_traffic();
        int           sent;
        int           phase;
        int           len;
        traffic_mix_t mix;
        logic [FUNC_W-1:0] op;
        sent  = 0;
        phase = 0;
        while (sent < RAND_ITEMS)
        begin
            mix = traffic_mix_t'($urandom_range(0, 2));
            if (phase % 5 == 0)
            begin
                in_gap_max    = 0;
                out_stall_max = 0;
            end
            else
            begin
                in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 3;
                out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            end
            len = $urandom_range(20, 80);
            for (int k = 0; k < len && sent < RAND_ITEMS; k++)
            begin
                op = pick_op(mix);
                send_op(op, pick_value(op));
                sent++;
            end
            if ($urandom_range(0, 4) == 0)
                wait_for_results();
            phase++;
        end
        out_stall_max = 3;
    endtask

    // Receiver: random stall per reply, then compare with the oldest expectation
    initial
    begin : reply_checker
        reply_t want;
        reply_t got;
        int     stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = $urandom_range(0, out_stall_max);
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(posedge clk);
                out_ready <= 1'b1;
            end
            do @(posedge clk); while (out_valid !== 1'b1 || out_ready !== 1'b1);
            got = '{result_value, found, status, occupancy};
            replies_seen++;
            if (pending_replies.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("reply %0d arrived with no operation outstanding", replies_seen);
            end
            else
            begin
                want = pending_replies.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"reply %0d: exp val=%h hit=%b st=%0d occ=%0d, ",
                                  "got val=%h hit=%b st=%0d occ=%0d"},
                                 replies_seen, want.ret_val, want.hit, want.stat, want.occ,
                                 got.ret_val, got.hit, got.stat, got.occ);
                end
            end
        end
    end

    // Ends the run when no transfer happens on either side for too long
    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < WDOG_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no transfer for %0d cycles, %0d replies outstanding",
                 WDOG_LIMIT, pending_replies.size());
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin : stimulus
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        test_empty_queue();
        test_fill_to_full();
        test_search_and_remove();
        test_pause_for_results();
        test_random_traffic();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_replies.size() != 0) @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);
        mismatches += pending_replies.size();
        $display("%0d operations sent, %0d replies checked, %0d mismatches",
                 items_sent, replies_seen, mismatches);
        $display("refused pushes %0d, empty pops %0d, search hits %0d, removals %0d",
                 n_full, n_empty, n_hits, n_removed);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
sv/sfq_pkg.sv
sv/sfq_seq.sv
sv/searchable_fifo_queue_unit.sv
verif/searchable_fifo_queue_unit_tb.sv
